/* rtl/core/lead_lag_compensator_core_assert.svh */
// assertion macros for the lead-lag compensator core
`ifndef LEAD_LAG_COMPENSATOR_CORE_ASSERT_SVH
`define LEAD_LAG_COMPENSATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LLC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("lead_lag_compensator_core: check failed");

// next-cycle implication, checked outside reset
`define LLC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("lead_lag_compensator_core: check failed");

`endif

/* rtl/core/llc_pkg.sv */
// types, constants and fixed-point helpers for the lead-lag compensator
`default_nettype none
package llc_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COEF_WIDTH   = 32;
  localparam int COEF_FRAC    = COEF_WIDTH - 8;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int RND_WIDTH    = PROD_WIDTH + 1;
  localparam int QUO_WIDTH    = RND_WIDTH - COEF_FRAC;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEAD_POLE = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEAD_B0   = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEAD_B1   = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LAG_POLE  = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LAG_B0    = CFG_IDX_WIDTH'(4);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LAG_B1    = CFG_IDX_WIDTH'(5);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOWER     = CFG_IDX_WIDTH'(6);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UPPER     = CFG_IDX_WIDTH'(7);

  localparam coef_t   COEF_ONE   = coef_t'(1) <<< COEF_FRAC;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [RND_WIDTH-1:0] RND_HALF = RND_WIDTH'(1) << (COEF_FRAC - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6
  } state_t;

  // scale product down, round half away from zero, saturate
  function automatic sample_t round_prod(input prod_t p);
    logic [RND_WIDTH-1:0] biased;
    logic [QUO_WIDTH-1:0] q;
    sample_t res;
    biased = {p[PROD_WIDTH-1], p} + (p[PROD_WIDTH-1] ? (RND_HALF - RND_WIDTH'(1)) : RND_HALF);
    q = biased[RND_WIDTH-1:COEF_FRAC];
    if (q[QUO_WIDTH-1:SAMPLE_WIDTH-1] == {(QUO_WIDTH-SAMPLE_WIDTH+1){q[QUO_WIDTH-1]}}) begin
      res = q[SAMPLE_WIDTH-1:0];
    end else begin
      res = q[QUO_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return res;
  endfunction

  // saturating sum or difference
  function automatic sample_t sat_add(input sample_t a, input sample_t b, input logic sub);
    logic [SAMPLE_WIDTH:0] s;
    sample_t res;
    if (sub) begin
      s = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
    end else begin
      s = {a[SAMPLE_WIDTH-1], a} + {b[SAMPLE_WIDTH-1], b};
    end
    if (s[SAMPLE_WIDTH] == s[SAMPLE_WIDTH-1]) begin
      res = s[SAMPLE_WIDTH-1:0];
    end else begin
      res = s[SAMPLE_WIDTH] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lead_lag_compensator_core.sv */
// lead-lag compensator: two first-order sections on one shared multiplier, then clamp
// steps from input beat to output beat: accept, six multiplies, clamp
// no new sample is taken until the last has passed the clamp; all products share the single 32x32 multiplier
// input is taken only in idle; a finished result may wait while the next sample runs
// the last step stalls if the previous result has not been taken
// reset (rst_n low, synchronous) clears both delays and loads bypass coefficients
`default_nettype none
`include "lead_lag_compensator_core_assert.svh"
module lead_lag_compensator_core
  import llc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [SAMPLE_WIDTH-1:0]   in_tdata,   // sample
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [SAMPLE_WIDTH-1:0]        out_tdata,  // drive
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  state_t  state_r, state_nxt;
  coef_t   lead_a_r, lead_b0_r, lead_b1_r, lag_a_r, lag_b0_r, lag_b1_r;
  sample_t lower_r, upper_r;
  sample_t lead_d_r, lag_d_r;
  sample_t x_r, y1_r, y2_r, t_r;
  prod_t   prod_r;
  sample_t out_data_r, out_data_nxt;
  logic    out_valid_r;
  coef_t   mul_a;
  sample_t mul_b;
  sample_t rp;
  logic    advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_a_r  <= '0;
      lead_b0_r <= COEF_ONE;
      lead_b1_r <= '0;
      lag_a_r   <= '0;
      lag_b0_r  <= COEF_ONE;
      lag_b1_r  <= '0;
      lower_r   <= SAMPLE_MIN;
      upper_r   <= SAMPLE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEAD_POLE: lead_a_r  <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LEAD_B0:   lead_b0_r <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LEAD_B1:   lead_b1_r <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LAG_POLE:  lag_a_r   <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LAG_B0:    lag_b0_r  <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LAG_B1:    lag_b1_r  <= cfg_wdata[COEF_WIDTH-1:0];
        REG_LOWER:     lower_r   <= cfg_wdata[SAMPLE_WIDTH-1:0];
        REG_UPPER:     upper_r   <= cfg_wdata[SAMPLE_WIDTH-1:0];
        default:       lower_r   <= lower_r;
      endcase
    end
  end

  assign advance = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_P4;
      ST_P4:   state_nxt = ST_P5;
      ST_P5:   state_nxt = ST_P6;
      ST_P6:   if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = lead_b0_r;
    mul_b = x_r;
    unique case (state_r)
      ST_P0:   begin mul_a = lead_b0_r; mul_b = x_r;  end
      ST_P1:   begin mul_a = lead_b1_r; mul_b = x_r;  end
      ST_P2:   begin mul_a = lead_a_r;  mul_b = y1_r; end
      ST_P3:   begin mul_a = lag_b0_r;  mul_b = y1_r; end
      ST_P4:   begin mul_a = lag_b1_r;  mul_b = y1_r; end
      ST_P5:   begin mul_a = lag_a_r;   mul_b = y2_r; end
      ST_P6:   begin mul_a = lag_a_r;   mul_b = y2_r; end
      default: begin mul_a = lead_b0_r; mul_b = x_r;  end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign rp = round_prod(prod_r);

  // clamp, lower limit first
  always_comb begin
    if (y2_r < lower_r) begin
      out_data_nxt = lower_r;
    end else if (y2_r > upper_r) begin
      out_data_nxt = upper_r;
    end else begin
      out_data_nxt = y2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lead_d_r    <= '0;
      lag_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_P6 && advance) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_P3: lead_d_r <= sat_add(t_r, rp, 1'b1);
        ST_P6: begin
          if (advance) begin
            lag_d_r <= sat_add(t_r, rp, 1'b1);
          end
        end
        default: lead_d_r <= lead_d_r;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == ST_IDLE && in_tvalid) x_r <= in_tdata;
    unique case (state_r)
      ST_P1:   y1_r <= sat_add(rp, lead_d_r, 1'b0);
      ST_P2:   t_r  <= rp;
      ST_P4:   y2_r <= sat_add(rp, lag_d_r, 1'b0);
      ST_P5:   t_r  <= rp;
      ST_P6:   if (advance) out_data_r <= out_data_nxt;
      default: t_r  <= t_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LLC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == ST_P0)
  `LLC_ASSERT_IMP(a_result_from_last, clk, rst_n, $rose(out_tvalid), $past(state_r == ST_P6))
  `LLC_ASSERT_NXT(a_stall_holds, clk, rst_n, state_r == ST_P6 && out_tvalid && !out_tready, state_r == ST_P6)
  `LLC_ASSERT_NXT(a_busy_no_accept, clk, rst_n, state_r == ST_P0, !in_tready)

endmodule
`default_nettype wire
